// ===== sv/swq_pkg.sv =====
// Shared constants, types and the per-step merge function of the sliding window quantile core.
`timescale 1ns / 1ps
package swq_pkg;

  localparam int SW_WINDOW = 240;
  localparam int SAMPLE_W  = 20;
  localparam int COUNT_W   = 32;
  localparam int IDX_W     = $clog2(SW_WINDOW);
  localparam int CNT_W     = $clog2(SW_WINDOW + 1);
  localparam int P95_NUM   = 95;
  localparam int P95_DEN   = 100;
  localparam int PREM_W    = $clog2(P95_DEN + P95_NUM);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]    count_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FIN
  } swq_state_t;

  typedef struct packed {
    logic rem_done;
    logic ins_done;
  } merge_flags_t;

  typedef struct packed {
    sample_t value;
    logic    skip;
    logic    take_new;
  } merge_res_t;

  // One output step of the sorted-list merge: drop the oldest value once, insert the new one.
  // p2, p1 and cur hold old entries i-1, i and i+1.
  function automatic merge_res_t merge_step(input sample_t      p2,
                                            input sample_t      p1,
                                            input sample_t      cur,
                                            input sample_t      new_v,
                                            input sample_t      rem_v,
                                            input count_t       i,
                                            input count_t       n_old,
                                            input logic         rem_need,
                                            input merge_flags_t flags);
    sample_t       head;
    sample_t       head2;
    logic [CNT_W:0] hidx;
    logic          hv;
    logic          hv2;
    logic          sk;
    merge_res_t    res;
    if (flags.rem_done && !flags.ins_done) begin
      head  = cur;
      head2 = cur;
      hidx  = {1'b0, i} + 1'b1;
    end else if (!flags.rem_done && flags.ins_done) begin
      head  = p2;
      head2 = p1;
      hidx  = {1'b0, i} - 1'b1;
    end else begin
      head  = p1;
      head2 = cur;
      hidx  = {1'b0, i};
    end
    hv  = hidx < {1'b0, n_old};
    hv2 = (hidx + 1'b1) < {1'b0, n_old};
    sk  = rem_need && !flags.rem_done && hv && (head == rem_v);
    if (sk) begin
      head = head2;
      hv   = hv2;
    end
    res.skip     = sk;
    res.take_new = !flags.ins_done && (!hv || (new_v <= head));
    res.value    = res.take_new ? new_v : head;
    return res;
  endfunction

endpackage

// ===== sv/sliding_window_quantiles_core.sv =====
// Sliding window median, p95 and maximum of raster and present frame timings.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------------------
//  in_      | input     | in_valid / in_ready       | raster_us, present_us (20 b each)
//  out_     | output    | out_valid / out_ready     | 3 stats per kind (20 b each), frames_seen
//
//  The core takes one item at a time: the next input transfer is accepted only after the result
//  of the previous one has gone into the output register. Each item takes one pass over the
//  sorted-entry memory, one entry read and one entry written back per cycle.
//  Reset clears the fill count, ring slot, saturating total and percentile index; both memories
//  are left undefined, and only entries already written are ever used.
//  A finished result sits in the output register while the next item is taken in; the core
//  holds at the end of a pass only if that register still has an untaken result.
//
module sliding_window_quantiles_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [swq_pkg::SAMPLE_W-1:0]      in_raster_us,
  input  logic [swq_pkg::SAMPLE_W-1:0]      in_present_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [swq_pkg::SAMPLE_W-1:0]      out_raster_median,
  output logic [swq_pkg::SAMPLE_W-1:0]      out_raster_p95,
  output logic [swq_pkg::SAMPLE_W-1:0]      out_raster_worst,
  output logic [swq_pkg::SAMPLE_W-1:0]      out_present_median,
  output logic [swq_pkg::SAMPLE_W-1:0]      out_present_p95,
  output logic [swq_pkg::SAMPLE_W-1:0]      out_present_worst,
  output logic [swq_pkg::COUNT_W-1:0]       out_frames_seen
);
  import swq_pkg::*;

  localparam count_t WIN_CNT = CNT_W'(SW_WINDOW);

  // Chronological ring of both samples, and the sorted list of both kinds, index-aligned.
  logic [2*SAMPLE_W-1:0] ring_mem   [SW_WINDOW];
  logic [2*SAMPLE_W-1:0] sorted_mem [SW_WINDOW];

  swq_state_t           state_r, state_nxt;
  count_t               t_r, t_nxt;
  count_t               filled_r;
  logic [IDX_W-1:0]     slot_r;
  logic [COUNT_W-1:0]   total_r;
  count_t               pidx_r;
  logic [PREM_W-1:0]    prem_r;
  logic                 full_old_r;
  logic                 out_valid_r, out_valid_nxt;

  sample_t              new_r_r, new_p_r;
  logic [2*SAMPLE_W-1:0] ring_q_r;
  logic [2*SAMPLE_W-1:0] sq_r;
  logic [2*SAMPLE_W-1:0] p1_r, p2_r;
  merge_flags_t         rf_r, pf_r;

  sample_t              cap_rmed_r, cap_rp95_r, cap_rwst_r;
  sample_t              cap_pmed_r, cap_pp95_r, cap_pwst_r;
  sample_t              o_rmed_r, o_rp95_r, o_rwst_r;
  sample_t              o_pmed_r, o_pp95_r, o_pwst_r;
  logic [COUNT_W-1:0]   o_total_r;

  logic                 accept;
  logic                 step_en;
  logic                 fin_load;
  logic                 rd_en;
  logic [CNT_W:0]       rd_next;
  logic [IDX_W-1:0]     rd_addr;
  count_t               step_i;
  count_t               n_old;
  count_t               med_idx;
  count_t               worst_idx;
  merge_res_t           r_res, p_res;

  // Control sequencing: take an item, sweep the sorted list, hand the result over.
  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    in_ready  = 1'b0;
    step_en   = 1'b0;
    fin_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_SWEEP;
          t_nxt     = '0;
        end
      end
      ST_SWEEP: begin
        step_en = 1'b1;
        t_nxt   = t_r + 1'b1;
        if (t_r == filled_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        fin_load = !out_valid_r || out_ready;
        if (fin_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign accept  = in_valid && in_ready;
  assign rd_next = {1'b0, t_r} + 1'b1;
  // Read entry 0 on the transfer, then two entries ahead of the write-back during the sweep.
  assign rd_en   = accept || (step_en && (rd_next < (CNT_W + 1)'(SW_WINDOW)));
  assign rd_addr = accept ? '0 : rd_next[IDX_W-1:0];

  assign step_i    = t_r - 1'b1;
  assign n_old     = full_old_r ? filled_r : filled_r - 1'b1;
  assign med_idx   = filled_r >> 1;
  assign worst_idx = filled_r - 1'b1;

  assign r_res = merge_step(p2_r[2*SAMPLE_W-1:SAMPLE_W], p1_r[2*SAMPLE_W-1:SAMPLE_W],
                            sq_r[2*SAMPLE_W-1:SAMPLE_W], new_r_r,
                            ring_q_r[2*SAMPLE_W-1:SAMPLE_W], step_i, n_old, full_old_r, rf_r);
  assign p_res = merge_step(p2_r[SAMPLE_W-1:0], p1_r[SAMPLE_W-1:0], sq_r[SAMPLE_W-1:0],
                            new_p_r, ring_q_r[SAMPLE_W-1:0], step_i, n_old, full_old_r, pf_r);

  assign out_valid_nxt = fin_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Memories: read the oldest ring entry on transfer, store the new pair on the first sweep cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_q_r <= ring_mem[slot_r];
    end
    if (step_en && (t_r == '0)) begin
      ring_mem[slot_r] <= {new_r_r, new_p_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sq_r <= sorted_mem[rd_addr];
    end
    if (step_en && (t_r != '0)) begin
      sorted_mem[step_i[IDX_W-1:0]] <= {r_res.value, p_res.value};
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      t_r         <= '0;
      filled_r    <= '0;
      slot_r      <= '0;
      total_r     <= '0;
      pidx_r      <= '0;
      prem_r      <= '0;
      full_old_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rf_r        <= '0;
      pf_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      t_r         <= t_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        full_old_r <= (filled_r == WIN_CNT);
        rf_r       <= '0;
        pf_r       <= '0;
        if (filled_r != WIN_CNT) begin
          filled_r <= filled_r + 1'b1;
          // Advance floor(95*(n-1)/100) by one step of n, carrying the remainder.
          if (filled_r != '0) begin
            if ((prem_r + PREM_W'(P95_NUM)) >= PREM_W'(P95_DEN)) begin
              prem_r <= prem_r + PREM_W'(P95_NUM) - PREM_W'(P95_DEN);
              pidx_r <= pidx_r + 1'b1;
            end else begin
              prem_r <= prem_r + PREM_W'(P95_NUM);
            end
          end
        end
        if (total_r != '1) begin
          total_r <= total_r + 1'b1;
        end
      end
      if (step_en && (t_r != '0)) begin
        rf_r.rem_done <= rf_r.rem_done || r_res.skip;
        rf_r.ins_done <= rf_r.ins_done || r_res.take_new;
        pf_r.rem_done <= pf_r.rem_done || p_res.skip;
        pf_r.ins_done <= pf_r.ins_done || p_res.take_new;
      end
      if (fin_load) begin
        slot_r <= (slot_r == IDX_W'(SW_WINDOW - 1)) ? '0 : slot_r + 1'b1;
      end
    end
  end

  // Datapath: latch samples, shift the read window, pick off the order statistics.
  always_ff @(posedge clk) begin
    if (accept) begin
      new_r_r <= in_raster_us;
      new_p_r <= in_present_us;
    end
    if (step_en) begin
      p2_r <= p1_r;
      p1_r <= sq_r;
    end
    if (step_en && (t_r != '0)) begin
      if (step_i == med_idx) begin
        cap_rmed_r <= r_res.value;
        cap_pmed_r <= p_res.value;
      end
      if (step_i == pidx_r) begin
        cap_rp95_r <= r_res.value;
        cap_pp95_r <= p_res.value;
      end
      if (step_i == worst_idx) begin
        cap_rwst_r <= r_res.value;
        cap_pwst_r <= p_res.value;
      end
    end
    if (fin_load) begin
      o_rmed_r  <= cap_rmed_r;
      o_rp95_r  <= cap_rp95_r;
      o_rwst_r  <= cap_rwst_r;
      o_pmed_r  <= cap_pmed_r;
      o_pp95_r  <= cap_pp95_r;
      o_pwst_r  <= cap_pwst_r;
      o_total_r <= total_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_raster_median  = o_rmed_r;
  assign out_raster_p95     = o_rp95_r;
  assign out_raster_worst   = o_rwst_r;
  assign out_present_median = o_pmed_r;
  assign out_present_p95    = o_pp95_r;
  assign out_present_worst  = o_pwst_r;
  assign out_frames_seen    = o_total_r;

  // Every sweep must have inserted the new sample and dropped the oldest exactly when full.
  a_sweep_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (rf_r.ins_done && pf_r.ins_done &&
                             (rf_r.rem_done == full_old_r) && (pf_r.rem_done == full_old_r)))
    else $error("sweep finished without a complete merge");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (filled_r <= WIN_CNT) && (slot_r < IDX_W'(SW_WINDOW)))
    else $error("fill count or ring slot out of range");

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("transfer taken while a sweep is in progress");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (total_r != '1)) |=> (total_r == $past(total_r) + 1'b1))
    else $error("frame count did not advance");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    fin_load |=> (out_valid_r && (o_total_r == total_r)))
    else $error("result register not loaded at end of sweep");

endmodule

// ===== verif/sliding_window_quantiles_core_tb.sv =====
// Self-checking testbench for the sliding window median / p95 / maximum core.
`timescale 1ns / 1ps
module sliding_window_quantiles_core_tb;
  import swq_pkg::*;

  // One result transfer: three order statistics per timing kind plus the frame count.
  typedef struct packed {
    sample_t              r_med;
    sample_t              r_p95;
    sample_t              r_worst;
    sample_t              p_med;
    sample_t              p_p95;
    sample_t              p_worst;
    logic [COUNT_W-1:0]   frames;
  } frame_stats_t;

  // One directed row: the two samples and, where it is obvious, the result typed in.
  typedef struct packed {
    sample_t      r;
    sample_t      p;
    logic         has_want;
    frame_stats_t want;
  } stim_row_t;

  localparam int DIR_N       = 20;
  localparam int PH_ITEMS    = 108;
  localparam int HOLD_CYCLES = 2000;
  localparam int TAIL_CYCLES = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  sample_t            in_raster_us = '0;
  sample_t            in_present_us = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sample_t            out_raster_median;
  sample_t            out_raster_p95;
  sample_t            out_raster_worst;
  sample_t            out_present_median;
  sample_t            out_present_p95;
  sample_t            out_present_worst;
  logic [COUNT_W-1:0] out_frames_seen;

  // Typed-in expectation that travels with the item currently offered.
  logic               typed_valid = 1'b0;
  frame_stats_t       typed_stats = '0;

  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_req_seq  = 0;
  int errors        = 0;

  frame_stats_t pending_stats[$];

  // Predictor state: time-ordered history and value-ordered copy of each window.
  sample_t            hist [2][SW_WINDOW];
  sample_t            ordered [2][SW_WINDOW];
  int                 hist_slot = 0;
  int                 hist_fill = 0;
  logic [COUNT_W-1:0] frames_total = '0;

  sliding_window_quantiles_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_raster_us       (in_raster_us),
    .in_present_us      (in_present_us),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_raster_median  (out_raster_median),
    .out_raster_p95     (out_raster_p95),
    .out_raster_worst   (out_raster_worst),
    .out_present_median (out_present_median),
    .out_present_p95    (out_present_p95),
    .out_present_worst  (out_present_worst),
    .out_frames_seen    (out_frames_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Drop the evicted value (first equal entry) from the sorted window of kind k, then insert
  // the new value after any equal entries.
  function automatic void reorder_window(input int k, input bit drop, input sample_t old_v,
                                         input sample_t new_v);
    int m;
    int j;
    m = hist_fill;
    if (drop) begin
      j = 0;
      while (j < m - 1 && ordered[k][j] != old_v) j++;
      while (j < m - 1) begin
        ordered[k][j] = ordered[k][j + 1];
        j++;
      end
      m--;
    end
    j = m;
    while (j > 0 && ordered[k][j - 1] > new_v) begin
      ordered[k][j] = ordered[k][j - 1];
      j--;
    end
    ordered[k][j] = new_v;
  endfunction

  // Advance the window by one frame and return the statistics it should report.
  function automatic frame_stats_t predict_frame(input sample_t r, input sample_t p);
    frame_stats_t s;
    bit           full;
    sample_t      old_r;
    sample_t      old_p;
    int           n;
    int           mid;
    int           hi;
    full  = (hist_fill == SW_WINDOW);
    old_r = hist[0][hist_slot];
    old_p = hist[1][hist_slot];
    reorder_window(0, full, old_r, r);
    reorder_window(1, full, old_p, p);
    hist[0][hist_slot] = r;
    hist[1][hist_slot] = p;
    hist_slot = (hist_slot == SW_WINDOW - 1) ? 0 : hist_slot + 1;
    if (!full) hist_fill++;
    // Saturation at the top of the 32-bit count is kept here but lies far beyond any run.
    if (frames_total != '1) frames_total++;
    n   = hist_fill;
    mid = n / 2;
    hi  = (P95_NUM * (n - 1)) / P95_DEN;
    s.r_med   = ordered[0][mid];
    s.r_p95   = ordered[0][hi];
    s.r_worst = ordered[0][n - 1];
    s.p_med   = ordered[1][mid];
    s.p_p95   = ordered[1][hi];
    s.p_worst = ordered[1][n - 1];
    s.frames  = frames_total;
    return s;
  endfunction

  // Append one expectation at the tail of the pending list.
  function automatic void enqueue_stats(input frame_stats_t s);
    pending_stats = {pending_stats, s};
  endfunction

  task automatic compare_stats(input frame_stats_t want, input frame_stats_t got);
    logic [31:0] w[7];
    logic [31:0] g[7];
    string       tag[7];
    w = '{32'(want.r_med), 32'(want.r_p95), 32'(want.r_worst), 32'(want.p_med),
          32'(want.p_p95), 32'(want.p_worst), want.frames};
    g = '{32'(got.r_med), 32'(got.r_p95), 32'(got.r_worst), 32'(got.p_med),
          32'(got.p_p95), 32'(got.p_worst), got.frames};
    tag = '{"raster_median", "raster_p95", "raster_worst", "present_median", "present_p95",
            "present_worst", "frames_seen"};
    for (int i = 0; i < 7; i++) begin
      if (w[i] !== g[i]) begin
        $display("%0t: %s expected %0h got %0h", $time, tag[i], w[i], g[i]);
        errors++;
      end
    end
  endtask

  // Check every result transfer against the oldest expectation, then record the expectation
  // of any input transfer at the same edge. Values read here are the ones before the edge.
  always @(posedge clk) begin : score
    frame_stats_t got;
    frame_stats_t calc;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_raster_median, out_raster_p95, out_raster_worst, out_present_median,
                out_present_p95, out_present_worst, out_frames_seen};
        if (pending_stats.size() == 0) begin
          $display("%0t: result expected none got frames_seen %0h", $time, out_frames_seen);
          errors++;
        end else begin
          compare_stats(pending_stats.pop_front(), got);
        end
      end
      if (in_valid && in_ready) begin
        calc = predict_frame(in_raster_us, in_present_us);
        enqueue_stats(typed_valid ? typed_stats : calc);
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever the sender asks for one.
  always @(negedge clk) begin : receiver
    int hold_left;
    int hold_seen;
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (hold_seen != hold_req_seq) begin
      hold_seen = hold_req_seq;
      hold_left = HOLD_CYCLES - 1;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Offer one frame and hold it until its transfer; idle first with the current probability.
  task automatic offer_frame(input sample_t r, input sample_t p, input logic has_want,
                             input frame_stats_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_raster_us  = r;
    in_present_us = p;
    typed_valid   = has_want;
    typed_stats   = want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mix of value shapes: wide random, heavy duplicates, near the top, single bits, a narrow band at 0x40000, extremes.
  function automatic sample_t pick_sample();
    int style;
    style = $urandom_range(9);
    case (style)
      4, 5: return sample_t'($urandom_range(7));
      6: return sample_t'(20'hFFFFF - $urandom_range(15));
      7: return sample_t'(1 << $urandom_range(SAMPLE_W - 1));
      8: return sample_t'(20'h40000 + $urandom_range(63));
      9: return $urandom_range(1) ? sample_t'(20'hFFFFF) : sample_t'(0);
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    stim_row_t dir_rows [DIR_N];
    int        sidle [4];
    int        rstall [4];

    // First three rows start from an empty window, so their statistics are plain to read.
    dir_rows[0]  = '{20'h00000, 20'hFFFFF, 1'b1,
                     '{20'h00000, 20'h00000, 20'h00000, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 32'd1}};
    dir_rows[1]  = '{20'hFFFFF, 20'h00000, 1'b1,
                     '{20'hFFFFF, 20'h00000, 20'hFFFFF, 20'hFFFFF, 20'h00000, 20'hFFFFF, 32'd2}};
    dir_rows[2]  = '{20'hFFFFF, 20'hFFFFF, 1'b1,
                     '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 32'd3}};
    dir_rows[3]  = '{20'h00001, 20'h00002, 1'b0, '0};
    dir_rows[4]  = '{20'hAAAAA, 20'h55555, 1'b0, '0};
    dir_rows[5]  = '{20'h55555, 20'hAAAAA, 1'b0, '0};
    dir_rows[6]  = '{20'h00007, 20'h00007, 1'b0, '0};
    dir_rows[7]  = '{20'h00007, 20'h00007, 1'b0, '0};
    dir_rows[8]  = '{20'h00007, 20'h00007, 1'b0, '0};
    dir_rows[9]  = '{20'h80000, 20'h7FFFF, 1'b0, '0};
    dir_rows[10] = '{20'h7FFFF, 20'h80000, 1'b0, '0};
    dir_rows[11] = '{20'h00010, 20'h00030, 1'b0, '0};
    dir_rows[12] = '{20'h00020, 20'h00020, 1'b0, '0};
    dir_rows[13] = '{20'h00030, 20'h00010, 1'b0, '0};
    dir_rows[14] = '{20'h00001, 20'h00400, 1'b0, '0};
    dir_rows[15] = '{20'h40000, 20'h00020, 1'b0, '0};
    dir_rows[16] = '{20'h00000, 20'h00000, 1'b0, '0};
    dir_rows[17] = '{20'hFFFFE, 20'h00001, 1'b0, '0};
    dir_rows[18] = '{20'h12345, 20'h6789A, 1'b0, '0};
    dir_rows[19] = '{20'hFFFFF, 20'hFFFFF, 1'b0, '0};

    sidle  = '{0, 63, 0, 19};
    rstall = '{0, 0, 63, 19};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      offer_frame(dir_rows[i].r, dir_rows[i].p, dir_rows[i].has_want, dir_rows[i].want);
    end

    // Random phases; the window fills during the third one and the ring wraps once before the end.
    for (int ph = 0; ph < 4; ph++) begin
      if (ph != 0) begin
        // Pause the sender until every pending result has come out.
        in_valid = 1'b0;
        while (pending_stats.size() != 0) @(negedge clk);
      end
      send_idle_pct = sidle[ph];
      rcv_stall_pct = rstall[ph];
      // Block the result side for a long stretch while frames keep coming, so the core backs up.
      if (ph == 1) hold_req_seq++;
      for (int i = 0; i < PH_ITEMS; i++) begin
        offer_frame(pick_sample(), pick_sample(), 1'b0, '0);
      end
    end

    in_valid = 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("sliding_window_quantiles_core test passed");
    end else begin
      $display("sliding_window_quantiles_core test failed");
    end
    $finish;
  end

  // Watchdog: many times the slowest legal run (full-window passes, stalls, hold-off).
  initial begin
    #4_000_000;
    $display("sliding_window_quantiles_core test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/swq_pkg.sv
sv/sliding_window_quantiles_core.sv
verif/sliding_window_quantiles_core_tb.sv
